// ----- rtl/core/cpu8alu_pkg.sv -----
package cpu8alu_pkg;

  localparam int unsigned OpW   = 5;
  localparam int unsigned ByteW = 8;
  localparam int unsigned AddrW = 16;

  // Input tdata: opcode, operand, mem_address, padded to whole bytes.
  localparam int unsigned InDataW  = 32;
  // Output tdata: result, strobe, address, A, X, Y, N, Z, C, V, padded to whole bytes.
  localparam int unsigned OutDataW = 56;

  typedef enum logic [OpW-1:0] {
    OP_ADC     = 5'd0,
    OP_SBC     = 5'd1,
    OP_ORA     = 5'd2,
    OP_AND     = 5'd3,
    OP_EOR     = 5'd4,
    OP_ASL_MEM = 5'd5,
    OP_LSR_MEM = 5'd6,
    OP_ROL_MEM = 5'd7,
    OP_ROR_MEM = 5'd8,
    OP_ASL_ACC = 5'd9,
    OP_LSR_ACC = 5'd10,
    OP_ROL_ACC = 5'd11,
    OP_ROR_ACC = 5'd12,
    OP_INC_MEM = 5'd13,
    OP_DEC_MEM = 5'd14,
    OP_INA     = 5'd15,
    OP_INX     = 5'd16,
    OP_INY     = 5'd17,
    OP_DEA     = 5'd18,
    OP_DEX     = 5'd19,
    OP_DEY     = 5'd20,
    OP_LDA     = 5'd21,
    OP_LDX     = 5'd22,
    OP_LDY     = 5'd23,
    OP_LDF     = 5'd24
  } op_e;

  typedef enum logic [1:0] {
    SH_ASL = 2'd0,
    SH_LSR = 2'd1,
    SH_ROL = 2'd2,
    SH_ROR = 2'd3
  } shift_e;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

  typedef struct packed {
    logic [ByteW-1:0] acc;
    logic [ByteW-1:0] x;
    logic [ByteW-1:0] y;
    flags_t           flags;
  } arch_t;

  typedef struct packed {
    logic [ByteW-1:0] value;
    logic             mem_write;
  } alu_res_t;

endpackage

// ----- rtl/core/cpu8_alu_flags_registers.sv -----
// Pipeline: an accepted transaction loads the input register, and the result register takes
// its result from there whenever the result register is empty or being drained.
// Throughput: one transaction per cycle; while a result is stalled the input register
// holds one more transaction and then the input side stalls.
// Reset clears A, X, Y, the N, Z, C and V flags and both pipeline valid bits, so no
// transaction is pending after reset.
module cpu8_alu_flags_registers (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // s_axis_tdata fields, low bit up: opcode[4:0], operand[12:5], mem_address[28:13], zero pad.
  input  logic [cpu8alu_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // m_axis_tdata fields, low bit up: result_value[7:0], mem_write[8], write_address[24:9],
  // acc_out[32:25], xidx_out[40:33], yidx_out[48:41], neg_flag[49], zero_flag[50],
  // carry_flag[51], overflow_flag[52], zero pad.
  output logic [cpu8alu_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready
);
  import cpu8alu_pkg::*;

  logic             in_valid_q;
  logic [OpW-1:0]   in_op_q;
  logic [ByteW-1:0] in_operand_q;
  logic [AddrW-1:0] in_addr_q;

  arch_t            state_q, state_d;
  alu_res_t         alu_res;

  logic             out_valid_q;
  logic [ByteW-1:0] out_value_q;
  logic             out_wr_q;
  logic [AddrW-1:0] out_addr_q;

  logic             advance;

  // The result register loads a waiting transaction whenever it is empty or being drained.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  cpu8alu_exec u_exec (
    .op_i      (in_op_q),
    .operand_i (in_operand_q),
    .state_i   (state_q),
    .state_o   (state_d),
    .res_o     (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q      <= s_axis_tdata[OpW-1:0];
      in_operand_q <= s_axis_tdata[OpW+ByteW-1:OpW];
      in_addr_q    <= s_axis_tdata[OpW+ByteW+AddrW-1:OpW+ByteW];
    end
    if (advance) begin
      out_value_q <= alu_res.value;
      out_wr_q    <= alu_res.mem_write;
      out_addr_q  <= alu_res.mem_write ? in_addr_q : '0;
    end
  end

  // The register and flag fields follow the architectural state, which moves
  // only when the result register loads, so they stay in step with the result.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000,
                          state_q.flags.v, state_q.flags.c, state_q.flags.z, state_q.flags.n,
                          state_q.y, state_q.x, state_q.acc,
                          out_addr_q, out_wr_q, out_value_q};

  a_in_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_op_q) && $stable(in_operand_q))
    else $error("input register lost a waiting transaction");

  a_state_only_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("architectural state changed without a transaction");

  a_unused_op_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_op_q > OP_LDF) |=> $stable(state_q) && out_value_q == '0 && !out_wr_q)
    else $error("unused opcode disturbed state or result");

  a_addr_zero_without_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_wr_q |-> out_addr_q == '0)
    else $error("write address set without a write strobe");

endmodule

// ----- rtl/core/cpu8alu_exec.sv -----
module cpu8alu_exec (
  input  logic [cpu8alu_pkg::OpW-1:0]   op_i,
  input  logic [cpu8alu_pkg::ByteW-1:0] operand_i,
  input  cpu8alu_pkg::arch_t            state_i,
  output cpu8alu_pkg::arch_t            state_o,
  output cpu8alu_pkg::alu_res_t         res_o
);
  import cpu8alu_pkg::*;

  logic [ByteW-1:0] addend;
  logic [ByteW:0]   sum;
  logic [ByteW-1:0] sum_r;
  logic             sum_v;

  // Returns {carry out, result}.
  function automatic logic [ByteW:0] shift_f(shift_e kind, logic [ByteW-1:0] v, logic cin);
    logic [ByteW:0] r;
    case (kind)
      SH_ASL:  r = {v[ByteW-1], v[ByteW-2:0], 1'b0};
      SH_ROL:  r = {v[ByteW-1], v[ByteW-2:0], cin};
      SH_LSR:  r = {v[0], 1'b0, v[ByteW-1:1]};
      SH_ROR:  r = {v[0], cin, v[ByteW-1:1]};
      default: r = '0;
    endcase
    return r;
  endfunction

  // Subtract is add of the inverted operand, so C set means no borrow.
  assign addend = (op_i == OP_SBC) ? ~operand_i : operand_i;
  assign sum    = {1'b0, state_i.acc} + {1'b0, addend} + {{ByteW{1'b0}}, state_i.flags.c};
  assign sum_r  = sum[ByteW-1:0];
  assign sum_v  = ~(state_i.acc[ByteW-1] ^ addend[ByteW-1]) & (state_i.acc[ByteW-1] ^ sum_r[ByteW-1]);

  always_comb begin
    logic [ByteW:0]   sh;
    logic [ByteW-1:0] r;
    logic             set_nz;
    state_o         = state_i;
    res_o.value     = '0;
    res_o.mem_write = 1'b0;
    sh              = '0;
    r               = '0;
    set_nz          = 1'b1;
    case (op_e'(op_i))
      OP_ADC, OP_SBC: begin
        r = sum_r;
        state_o.acc = r;
        state_o.flags.c = sum[ByteW];
        state_o.flags.v = sum_v;
      end
      OP_ORA: begin
        r = state_i.acc | operand_i;
        state_o.acc = r;
      end
      OP_AND: begin
        r = state_i.acc & operand_i;
        state_o.acc = r;
      end
      OP_EOR: begin
        r = state_i.acc ^ operand_i;
        state_o.acc = r;
      end
      OP_ASL_MEM, OP_LSR_MEM, OP_ROL_MEM, OP_ROR_MEM: begin
        sh = shift_f(shift_e'(2'(op_i - OP_ASL_MEM)), operand_i, state_i.flags.c);
        r = sh[ByteW-1:0];
        state_o.flags.c = sh[ByteW];
        res_o.mem_write = 1'b1;
      end
      OP_ASL_ACC, OP_LSR_ACC, OP_ROL_ACC, OP_ROR_ACC: begin
        sh = shift_f(shift_e'(2'(op_i - OP_ASL_ACC)), state_i.acc, state_i.flags.c);
        r = sh[ByteW-1:0];
        state_o.acc = r;
        state_o.flags.c = sh[ByteW];
      end
      OP_INC_MEM: begin
        r = operand_i + 8'd1;
        res_o.mem_write = 1'b1;
      end
      OP_DEC_MEM: begin
        r = operand_i - 8'd1;
        res_o.mem_write = 1'b1;
      end
      OP_INA: begin
        r = state_i.acc + 8'd1;
        state_o.acc = r;
      end
      OP_INX: begin
        r = state_i.x + 8'd1;
        state_o.x = r;
      end
      OP_INY: begin
        r = state_i.y + 8'd1;
        state_o.y = r;
      end
      OP_DEA: begin
        r = state_i.acc - 8'd1;
        state_o.acc = r;
      end
      OP_DEX: begin
        r = state_i.x - 8'd1;
        state_o.x = r;
      end
      OP_DEY: begin
        r = state_i.y - 8'd1;
        state_o.y = r;
      end
      OP_LDA: begin
        r = operand_i;
        state_o.acc = r;
      end
      OP_LDX: begin
        r = operand_i;
        state_o.x = r;
      end
      OP_LDY: begin
        r = operand_i;
        state_o.y = r;
      end
      OP_LDF: begin
        r = operand_i;
        set_nz = 1'b0;
        state_o.flags.n = operand_i[7];
        state_o.flags.v = operand_i[6];
        state_o.flags.z = operand_i[1];
        state_o.flags.c = operand_i[0];
      end
      default: begin
        set_nz = 1'b0;
      end
    endcase
    if (set_nz) begin
      state_o.flags.n = r[ByteW-1];
      state_o.flags.z = (r == '0);
    end
    res_o.value = r;
  end

endmodule

// ----- bench/tb_cpu8_alu_flags_registers.sv -----
module tb_cpu8_alu_flags_registers;
  import cpu8alu_pkg::*;

  localparam int unsigned NumRandomOps = 1550;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned HoldOffLen   = 300;
  localparam int unsigned HoldOffAt    = 500;

  typedef struct {
    logic [ByteW-1:0] value;
    logic             wr;
    logic [AddrW-1:0] waddr;
    logic [ByteW-1:0] acc;
    logic [ByteW-1:0] xr;
    logic [ByteW-1:0] yr;
    flags_t           fl;
  } alu_result_t;

  // Tracks the architectural registers and holds the results still owed by the block.
  class alu_checker;
    logic [ByteW-1:0] acc;
    logic [ByteW-1:0] xr;
    logic [ByteW-1:0] yr;
    flags_t           fl;
    alu_result_t      pending_results[$];
    int unsigned      errors;

    function void clear_regs();
      acc = '0;
      xr  = '0;
      yr  = '0;
      fl  = '0;
    endfunction

    function logic [ByteW-1:0] set_nz(logic [ByteW-1:0] v);
      fl.n = v[7];
      fl.z = (v == '0);
      return v;
    endfunction

    function logic [ByteW-1:0] shift_byte(shift_e kind, logic [ByteW-1:0] v);
      logic             cin;
      logic [ByteW-1:0] r;
      cin = fl.c;
      case (kind)
        SH_ASL: begin
          fl.c = v[7];
          r = {v[6:0], 1'b0};
        end
        SH_ROL: begin
          fl.c = v[7];
          r = {v[6:0], cin};
        end
        SH_LSR: begin
          fl.c = v[0];
          r = {1'b0, v[7:1]};
        end
        default: begin
          fl.c = v[0];
          r = {cin, v[7:1]};
        end
      endcase
      return set_nz(r);
    endfunction

    // Applies one operation to the tracked registers and queues the result it produces.
    function void note_issue(logic [OpW-1:0] op, logic [ByteW-1:0] m, logic [AddrW-1:0] addr);
      alu_result_t      r;
      logic [ByteW-1:0] res;
      logic [ByteW-1:0] b;
      logic [ByteW:0]   sum;
      logic             wr;
      res = '0;
      wr  = 1'b0;
      case (op)
        OP_ADC, OP_SBC: begin
          // Subtract is add of the inverted operand, so carry set means no borrow.
          b    = (op == OP_SBC) ? ~m : m;
          sum  = {1'b0, acc} + {1'b0, b} + {{ByteW{1'b0}}, fl.c};
          res  = sum[ByteW-1:0];
          fl.c = sum[ByteW];
          fl.v = ~(acc[7] ^ b[7]) & (acc[7] ^ res[7]);
          acc  = set_nz(res);
        end
        OP_ORA: begin
          res = set_nz(acc | m);
          acc = res;
        end
        OP_AND: begin
          res = set_nz(acc & m);
          acc = res;
        end
        OP_EOR: begin
          res = set_nz(acc ^ m);
          acc = res;
        end
        OP_ASL_MEM, OP_LSR_MEM, OP_ROL_MEM, OP_ROR_MEM: begin
          res = shift_byte(shift_e'(2'(op - OP_ASL_MEM)), m);
          wr  = 1'b1;
        end
        OP_ASL_ACC, OP_LSR_ACC, OP_ROL_ACC, OP_ROR_ACC: begin
          res = shift_byte(shift_e'(2'(op - OP_ASL_ACC)), acc);
          acc = res;
        end
        OP_INC_MEM: begin
          res = set_nz(m + 8'd1);
          wr  = 1'b1;
        end
        OP_DEC_MEM: begin
          res = set_nz(m - 8'd1);
          wr  = 1'b1;
        end
        OP_INA: begin
          res = set_nz(acc + 8'd1);
          acc = res;
        end
        OP_INX: begin
          res = set_nz(xr + 8'd1);
          xr  = res;
        end
        OP_INY: begin
          res = set_nz(yr + 8'd1);
          yr  = res;
        end
        OP_DEA: begin
          res = set_nz(acc - 8'd1);
          acc = res;
        end
        OP_DEX: begin
          res = set_nz(xr - 8'd1);
          xr  = res;
        end
        OP_DEY: begin
          res = set_nz(yr - 8'd1);
          yr  = res;
        end
        OP_LDA: begin
          res = set_nz(m);
          acc = res;
        end
        OP_LDX: begin
          res = set_nz(m);
          xr  = res;
        end
        OP_LDY: begin
          res = set_nz(m);
          yr  = res;
        end
        OP_LDF: begin
          fl.n = m[7];
          fl.v = m[6];
          fl.z = m[1];
          fl.c = m[0];
          res  = m;
        end
        default: begin
          // Unused opcodes leave every register alone and return a zero byte.
        end
      endcase
      r.value = res;
      r.wr    = wr;
      r.waddr = wr ? addr : '0;
      r.acc   = acc;
      r.xr    = xr;
      r.yr    = yr;
      r.fl    = fl;
      pending_results.push_back(r);
    endfunction

    function void compare(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_retire(logic [OutDataW-1:0] td);
      alu_result_t e;
      if (pending_results.size() == 0) begin
        $error("result transaction with no operation outstanding: tdata 0x%0h", td);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      compare("result_value", 16'(e.value), 16'(td[7:0]));
      compare("mem_write", 16'(e.wr), 16'(td[8]));
      compare("write_address", e.waddr, td[24:9]);
      compare("acc_out", 16'(e.acc), 16'(td[32:25]));
      compare("xidx_out", 16'(e.xr), 16'(td[40:33]));
      compare("yidx_out", 16'(e.yr), 16'(td[48:41]));
      compare("neg_flag", 16'(e.fl.n), 16'(td[49]));
      compare("zero_flag", 16'(e.fl.z), 16'(td[50]));
      compare("carry_flag", 16'(e.fl.c), 16'(td[51]));
      compare("overflow_flag", 16'(e.fl.v), 16'(td[52]));
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;

  alu_checker  chk;
  int unsigned results_seen = 0;
  int unsigned idle_cycles  = 0;

  cpu8_alu_flags_registers u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  always #5 clk_i = ~clk_i;

  // Ends the run if neither side completes a transaction for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic issue_op(logic [OpW-1:0] op, logic [ByteW-1:0] m, logic [AddrW-1:0] addr,
                          int unsigned gap);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, addr, m, op};
    do @(posedge clk_i); while (!s_axis_tready);
    chk.note_issue(op, m, addr);
  endtask

  task automatic drain_results();
    int unsigned gap;
    forever begin
      if (results_seen == HoldOffAt) begin
        // One long hold-off lets the pipeline fill and back up into the input side.
        gap = HoldOffLen;
      end else if ((results_seen / 100) % 3 == 0) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 14);
      end
      @(negedge clk_i);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      chk.check_retire(m_axis_tdata);
      results_seen++;
    end
  endtask

  task automatic run_directed();
    issue_op(OP_LDF, 8'h01, 16'h0000, $urandom_range(0, 14));
    issue_op(OP_LDA, 8'h7F, 16'hFFFF, $urandom_range(0, 14));
    issue_op(OP_ADC, 8'h00, 16'h1234, $urandom_range(0, 14));
    issue_op(OP_ADC, 8'hFF, 16'h0000, $urandom_range(0, 14));
    issue_op(OP_SBC, 8'h00, 16'hFFFF, $urandom_range(0, 14));
    issue_op(OP_SBC, 8'hFF, 16'h0000, $urandom_range(0, 14));
    issue_op(OP_ORA, 8'hF0, 16'h0000, $urandom_range(0, 14));
    issue_op(OP_AND, 8'h0F, 16'h0000, $urandom_range(0, 14));
    issue_op(OP_EOR, 8'hFF, 16'h0000, $urandom_range(0, 14));
    issue_op(OP_ASL_MEM, 8'h81, 16'hFFFF, $urandom_range(0, 14));
    issue_op(OP_LSR_MEM, 8'h01, 16'h0000, $urandom_range(0, 14));
    issue_op(OP_ROL_MEM, 8'h80, 16'hAAAA, $urandom_range(0, 14));
    issue_op(OP_ROR_MEM, 8'h01, 16'h5555, $urandom_range(0, 14));
    issue_op(OP_ASL_ACC, 8'h00, 16'h0000, $urandom_range(0, 14));
    issue_op(OP_LSR_ACC, 8'h00, 16'h0000, $urandom_range(0, 14));
    issue_op(OP_ROL_ACC, 8'h00, 16'h0000, $urandom_range(0, 14));
    issue_op(OP_ROR_ACC, 8'h00, 16'h0000, $urandom_range(0, 14));
    issue_op(OP_INC_MEM, 8'hFF, 16'h8000, $urandom_range(0, 14));
    issue_op(OP_DEC_MEM, 8'h00, 16'h0001, $urandom_range(0, 14));
    issue_op(OP_LDX, 8'hFF, 16'h0000, $urandom_range(0, 14));
    issue_op(OP_INX, 8'h00, 16'h0000, $urandom_range(0, 14));
    issue_op(OP_LDY, 8'h80, 16'h0000, $urandom_range(0, 14));
    issue_op(OP_DEY, 8'h00, 16'h0000, $urandom_range(0, 14));
    issue_op(OP_INY, 8'h00, 16'h0000, $urandom_range(0, 14));
    issue_op(OP_DEX, 8'h00, 16'h0000, $urandom_range(0, 14));
    issue_op(OP_INA, 8'h00, 16'h0000, $urandom_range(0, 14));
    issue_op(OP_DEA, 8'h00, 16'h0000, $urandom_range(0, 14));
    issue_op(OP_LDF, 8'hC3, 16'h0000, $urandom_range(0, 14));
    issue_op(5'd25, 8'hFF, 16'hFFFF, $urandom_range(0, 14));
    issue_op(5'd31, 8'hFF, 16'hFFFF, $urandom_range(0, 14));
  endtask

  task automatic run_random();
    logic [ByteW-1:0] corner_bytes[4];
    logic [OpW-1:0]   op;
    logic [ByteW-1:0] m;
    int unsigned      gap;
    corner_bytes = '{8'h00, 8'h7F, 8'h80, 8'hFF};
    for (int unsigned i = 0; i < NumRandomOps; i++) begin
      if ($urandom_range(0, 99) < 5) begin
        op = OpW'($urandom_range(25, 31));
      end else begin
        op = OpW'($urandom_range(0, 24));
      end
      if ($urandom_range(0, 4) == 0) begin
        m = corner_bytes[$urandom_range(0, 3)];
      end else begin
        m = ByteW'($urandom_range(0, 255));
      end
      gap = ((i / 64) % 3 == 0) ? 0 : $urandom_range(0, 14);
      issue_op(op, m, AddrW'($urandom_range(0, 65535)), gap);
    end
  endtask

  initial begin
    chk = new();
    chk.clear_regs();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    fork
      drain_results();
    join_none
    run_directed();
    run_random();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (chk.pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (chk.errors == 0 && chk.pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/cpu8alu_pkg.sv
rtl/core/cpu8alu_exec.sv
rtl/core/cpu8_alu_flags_registers.sv
bench/tb_cpu8_alu_flags_registers.sv
